### design/feistel_byte_pair_decrypt_defines.svh
// assertion macros used by the checker file fbpd_checker.sv
`ifndef FEISTEL_BYTE_PAIR_DECRYPT_DEFINES_SVH
`define FEISTEL_BYTE_PAIR_DECRYPT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FBPD_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("fbpd check failed");

// next-cycle implication, checked outside reset
`define FBPD_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("fbpd check failed");

`endif

### design/fbpd_pkg.sv
package fbpd_pkg;

	localparam int FBPD_MAX_ROUNDS = 8;
	localparam logic [7:0] SPACE_CODE = 8'h20;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_ROUND_COUNT     = 2'd0,
		CFG_ROUND_KEYS      = 2'd1,
		CFG_FUNCTION_SELECT = 2'd2
	} cfg_idx_t;

	// round function codes
	localparam logic [2:0] FN_OR_HI   = 3'd0;
	localparam logic [2:0] FN_AND_LO  = 3'd1;
	localparam logic [2:0] FN_OR_HI_B = 3'd2;
	localparam logic [2:0] FN_XOR_HI  = 3'd3;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] right;
	} half_pair_t;

	// per-cell round control
	typedef struct packed {
		logic       active;
		logic [7:0] key;
		logic [2:0] fsel;
	} round_ctl_t;

	function automatic logic [7:0] round_fn(input logic [2:0] sel, input logic [7:0] m,
		input logic [7:0] k);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] res;
		hi = {4'd0, k[7:4]};
		lo = {4'd0, k[3:0]};
		case (sel) inside
			FN_OR_HI, FN_OR_HI_B: res = (m | k) ^ (hi & m);
			FN_AND_LO:            res = (m & k) | (lo ^ m);
			FN_XOR_HI:            res = (m ^ k) & (hi | m);
			default:              res = (m & k) ^ (lo | m);
		endcase
		return res;
	endfunction

	function automatic logic [7:0] zero_to_space(input logic [7:0] v);
		return (v == 8'd0) ? SPACE_CODE : v;
	endfunction

endpackage

### design/feistel_byte_pair_decrypt.sv
// channel  | dir | payload
// s_axis   | in  | tdata[7:0] first_byte, tdata[15:8] second_byte
// m_axis   | out | tdata[7:0] plain_first, tdata[15:8] plain_second
// cfg      | in  | cfg_index register index, cfg_data write value
//
// one round cell per stage, each with its own register
// one request accepted per cycle when the output is taken each cycle
// a stalled output fills the empty cells first; input stalls only when every cell is full
// reset clears the cell valid bits and all configuration registers to zero
// cfg_ready is always high; a write takes effect on the next cycle
module feistel_byte_pair_decrypt #(
	parameter int MAX_ROUNDS = fbpd_pkg::FBPD_MAX_ROUNDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] plain_first, [15:8] plain_second
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import fbpd_pkg::*;

	logic [3:0]  round_count_q;
	logic [63:0] round_keys_q;
	logic [2:0]  function_select_q;
	logic [3:0]  n_rounds;

	logic       valid [MAX_ROUNDS+1];
	logic       ready [MAX_ROUNDS+1];
	half_pair_t data  [MAX_ROUNDS+1];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q     <= '0;
			round_keys_q      <= '0;
			function_select_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROUND_COUNT:     round_count_q     <= cfg_data[3:0];
				CFG_ROUND_KEYS:      round_keys_q      <= cfg_data;
				CFG_FUNCTION_SELECT: function_select_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// rounds in use, saturated at the cell count
	assign n_rounds = (round_count_q > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : round_count_q;

	// input side of the chain
	assign valid[0]       = s_axis_tvalid;
	assign data[0].right  = s_axis_tdata[7:0];
	assign data[0].left   = s_axis_tdata[15:8];
	assign s_axis_tready  = ready[0];

	// cell s runs key n-1-s, so the last key is used first
	for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_cell
		round_ctl_t ctl;
		logic [3:0] key_idx;

		assign key_idx    = n_rounds - 4'(s) - 4'd1;
		assign ctl.active = 4'(s) < n_rounds;
		assign ctl.key    = round_keys_q[key_idx[2:0]*8 +: 8];
		assign ctl.fsel   = function_select_q;

		fbpd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.in_valid (valid[s]),
			.in_data  (data[s]),
			.in_ready (ready[s]),
			.out_valid(valid[s+1]),
			.out_data (data[s+1]),
			.out_ready(ready[s+1])
		);
	end

	// output side, zero bytes shown as spaces
	assign ready[MAX_ROUNDS]  = m_axis_tready;
	assign m_axis_tvalid      = valid[MAX_ROUNDS];
	assign m_axis_tdata[7:0]  = zero_to_space(data[MAX_ROUNDS].left);
	assign m_axis_tdata[15:8] = zero_to_space(data[MAX_ROUNDS].right);

endmodule

### design/fbpd_cell.sv
module fbpd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  fbpd_pkg::round_ctl_t ctl,
	input  logic               in_valid,
	input  fbpd_pkg::half_pair_t in_data,
	output logic               in_ready,
	output logic               out_valid,
	output fbpd_pkg::half_pair_t out_data,
	input  logic               out_ready
);
	import fbpd_pkg::*;

	logic       valid_q;
	half_pair_t data_q;
	half_pair_t next_data;

	// one feistel round, or pass through when this cell is past the round count
	always_comb begin
		next_data = in_data;
		if (ctl.active) begin
			next_data.left  = in_data.right ^ round_fn(ctl.fsel, in_data.left, ctl.key);
			next_data.right = in_data.left;
		end
	end

	// stage takes a request when empty or when its neighbor takes the held one
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### design/fbpd_checker.sv
`include "feistel_byte_pair_decrypt_defines.svh"

module fbpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// configuration port never back-pressures
	`FBPD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

	// results never carry a zero byte
	`FBPD_ASSERT_NOW(a_no_zero, m_axis_tvalid, (m_axis_tdata[7:0] != 8'd0) && (m_axis_tdata[15:8] != 8'd0))

	// input stalls only when a result is held at the output
	`FBPD_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// a held result stays put
	`FBPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind feistel_byte_pair_decrypt fbpd_checker u_fbpd_checker (.*);
